[sv/p2sc_pkg.sv]
// Shared types and constants of the polar to scaled Cartesian converter.
// Fixed-point widths, angle constants and the CORDIC arctangent table.
// No dependencies.
`default_nettype none

package p2sc_pkg;

    // input and output field widths
    localparam int DIST_W  = 16;
    localparam int BEAR_W  = 15;
    localparam int POS_W   = 21;
    localparam int SCALE_W = 4;

    // stream word widths, padded to bytes
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 48;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_X_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_SCALE = 2'd1;
    localparam logic [SCALE_W-1:0] X_SCALE_RST = 4'd6;
    localparam logic [SCALE_W-1:0] Y_SCALE_RST = 4'd9;

    // angle in 1/64 degree
    localparam int ANG_W = 16;
    localparam int MAG_W = 13;
    localparam logic [BEAR_W-1:0] TURN_U   = 15'd23040;
    localparam logic signed [ANG_W-1:0] TURN    = 16'sd23040;
    localparam logic signed [ANG_W-1:0] HALF    = 16'sd11520;
    localparam logic signed [ANG_W-1:0] QUARTER = 16'sd5760;

    // 1/64 degree to Q46 radians, CORDIC gain in Q30
    localparam int DEG_K_W  = 35;
    localparam int GAIN_W   = 30;
    localparam logic [DEG_K_W-1:0] DEG64_TO_Q46 = 35'd19190098068;
    localparam logic [GAIN_W-1:0]  GAIN_Q30     = 30'd652032874;
    localparam int ZPROD_W = MAG_W + DEG_K_W;
    localparam int X0_W    = DIST_W + GAIN_W;

    // datapath widths: x/y up to distance * 2^30, z up to pi/2 in Q30
    localparam int XW = 49;
    localparam int ZW = 34;
    localparam int PW = XW + SCALE_W + 1;

    localparam logic [POS_W-1:0] OUT_LIMIT = 21'd983025;

    localparam int ATAN_LEN = 24;
    localparam int ATAN_W   = 31;
    localparam logic [ATAN_W-1:0] ATAN_Q30 [0:ATAN_LEN-1] = '{
        31'd843314856, 31'd497837829, 31'd263043836, 31'd133525158,
        31'd67021686,  31'd33543515,  31'd16775850,  31'd8388437,
        31'd4194282,   31'd2097149,   31'd1048575,   31'd524287,
        31'd262143,    31'd131071,    31'd65535,     31'd32767,
        31'd16383,     31'd8191,      31'd4095,      31'd2047,
        31'd1023,      31'd511,       31'd255,       31'd127
    };

    typedef struct packed {
        logic negt;
        logic flip;
    } t_side;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        t_side                side;
    } t_cw;

endpackage

`default_nettype wire

[sv/p2sc_angle.sv]
// Angle front end: folds the bearing into +-90 degrees, converts it to Q30
// radians and loads the CORDIC start vector. Two register stages.
// Depends on p2sc_pkg.
`default_nettype none

module p2sc_angle (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_en,
    input  wire                            i_valid,
    input  wire  [p2sc_pkg::DIST_W-1:0]    i_distance,
    input  wire  [p2sc_pkg::BEAR_W-1:0]    i_bearing,
    output logic                           o_valid,
    output p2sc_pkg::t_cw                  o_word
);

    // stage 1: fold
    logic                           r_v1;
    logic [p2sc_pkg::DIST_W-1:0]    r_dist;
    logic [p2sc_pkg::MAG_W-1:0]     r_mag;
    p2sc_pkg::t_side                r_side;

    logic [p2sc_pkg::BEAR_W-1:0]        b;
    logic signed [p2sc_pkg::ANG_W-1:0]  t;
    logic signed [p2sc_pkg::ANG_W-1:0]  t_abs;
    logic [p2sc_pkg::MAG_W-1:0]         n_mag;
    p2sc_pkg::t_side                    n_side;

    always_comb begin
        b = (i_bearing >= p2sc_pkg::TURN_U) ? i_bearing - p2sc_pkg::TURN_U : i_bearing;
        t = $signed({1'b0, b}) - p2sc_pkg::QUARTER;
        if (t > p2sc_pkg::HALF) begin
            t = t - p2sc_pkg::TURN;
        end
        n_side.flip = 1'b0;
        if (t > p2sc_pkg::QUARTER) begin
            t = t - p2sc_pkg::HALF;
            n_side.flip = 1'b1;
        end else if (t < -p2sc_pkg::QUARTER) begin
            t = t + p2sc_pkg::HALF;
            n_side.flip = 1'b1;
        end
        n_side.negt = t[p2sc_pkg::ANG_W-1];
        t_abs = n_side.negt ? -t : t;
        n_mag = t_abs[p2sc_pkg::MAG_W-1:0];
    end

    // stage 2: radians and start vector
    logic                            r_v2;
    p2sc_pkg::t_cw                   r_word;
    logic [p2sc_pkg::ZPROD_W-1:0]    zprod;
    logic [p2sc_pkg::ZPROD_W-1:0]    zrnd;
    logic [p2sc_pkg::X0_W-1:0]       x0;
    p2sc_pkg::t_cw                   n_word;

    always_comb begin
        zprod = p2sc_pkg::ZPROD_W'(r_mag) * p2sc_pkg::ZPROD_W'(p2sc_pkg::DEG64_TO_Q46);
        zrnd  = zprod + p2sc_pkg::ZPROD_W'(32768);
        x0    = p2sc_pkg::X0_W'(r_dist) * p2sc_pkg::X0_W'(p2sc_pkg::GAIN_Q30);
        n_word.x    = $signed({{(p2sc_pkg::XW-p2sc_pkg::X0_W){1'b0}}, x0});
        n_word.y    = '0;
        n_word.z    = $signed({{(p2sc_pkg::ZW-(p2sc_pkg::ZPROD_W-16)){1'b0}},
                               zrnd[p2sc_pkg::ZPROD_W-1:16]});
        n_word.side = r_side;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dist <= i_distance;
            r_mag  <= n_mag;
            r_side <= n_side;
            r_word <= n_word;
        end
    end

    assign o_valid = r_v2;
    assign o_word  = r_word;

endmodule

`default_nettype wire

[sv/p2sc_cordic.sv]
// Rotation-mode CORDIC, one register stage per iteration.
// Depends on p2sc_pkg for the word type and the arctangent table.
`default_nettype none

module p2sc_cordic #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire                 i_valid,
    input  wire p2sc_pkg::t_cw  i_word,
    output logic                o_valid,
    output p2sc_pkg::t_cw       o_word
);

    logic          r_v [CORDIC_STAGES];
    p2sc_pkg::t_cw r_w [CORDIC_STAGES];

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
        logic                              v_in;
        p2sc_pkg::t_cw                     w_in;
        p2sc_pkg::t_cw                     n_w;
        logic signed [p2sc_pkg::XW-1:0]    dx;
        logic signed [p2sc_pkg::XW-1:0]    dy;
        logic signed [p2sc_pkg::ZW-1:0]    ang;

        if (k == 0) begin : g_first
            assign v_in = i_valid;
            assign w_in = i_word;
        end else begin : g_next
            assign v_in = r_v[k-1];
            assign w_in = r_w[k-1];
        end

        always_comb begin
            dx  = w_in.y >>> k;
            dy  = w_in.x >>> k;
            ang = $signed({{(p2sc_pkg::ZW-p2sc_pkg::ATAN_W){1'b0}}, p2sc_pkg::ATAN_Q30[k]});
            n_w.side = w_in.side;
            // rotate toward zero residual angle
            if (!w_in.z[p2sc_pkg::ZW-1]) begin
                n_w.x = w_in.x - dx;
                n_w.y = w_in.y + dy;
                n_w.z = w_in.z - ang;
            end else begin
                n_w.x = w_in.x + dx;
                n_w.y = w_in.y - dy;
                n_w.z = w_in.z + ang;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_w[k] <= n_w;
            end
        end
    end

    assign o_valid = r_v[CORDIC_STAGES-1];
    assign o_word  = r_w[CORDIC_STAGES-1];

endmodule

`default_nettype wire

[sv/p2sc_scale.sv]
// Back end: restores quadrant signs, applies the scale gains, then rounds
// Q30 to integers with saturation. Two register stages. Depends on p2sc_pkg.
`default_nettype none

module p2sc_scale (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_en,
    input  wire                                i_valid,
    input  wire p2sc_pkg::t_cw                 i_word,
    input  wire  [p2sc_pkg::SCALE_W-1:0]       i_x_scale,
    input  wire  [p2sc_pkg::SCALE_W-1:0]       i_y_scale,
    output logic                               o_valid,
    output logic signed [p2sc_pkg::POS_W-1:0]  o_pos_x,
    output logic signed [p2sc_pkg::POS_W-1:0]  o_pos_y
);

    // stage 1: signs and gains
    logic                            r_v1;
    logic signed [p2sc_pkg::PW-1:0]  r_p;
    logic signed [p2sc_pkg::PW-1:0]  r_q;
    logic signed [p2sc_pkg::XW-1:0]  s;
    logic signed [p2sc_pkg::XW-1:0]  c;
    logic signed [p2sc_pkg::PW-1:0]  n_p;
    logic signed [p2sc_pkg::PW-1:0]  n_q;

    always_comb begin
        s = i_word.side.negt ? -i_word.y : i_word.y;
        c = i_word.x;
        if (i_word.side.flip) begin
            s = -s;
            c = -c;
        end
        n_p = $signed({{(p2sc_pkg::PW-p2sc_pkg::SCALE_W){1'b0}}, i_x_scale})
              * p2sc_pkg::PW'(s);
        n_q = $signed({{(p2sc_pkg::PW-p2sc_pkg::SCALE_W){1'b0}}, i_y_scale})
              * p2sc_pkg::PW'(c);
    end

    // stage 2: round half away from zero, saturate
    function automatic logic signed [p2sc_pkg::POS_W-1:0] round_sat(
        input logic signed [p2sc_pkg::PW-1:0] v
    );
        logic                     neg;
        logic [p2sc_pkg::PW-1:0]  mag;
        logic [p2sc_pkg::PW-1:0]  rnd;
        logic [p2sc_pkg::POS_W-1:0] lim;
        neg = v[p2sc_pkg::PW-1];
        mag = neg ? p2sc_pkg::PW'(-v) : p2sc_pkg::PW'(v);
        rnd = (mag + (p2sc_pkg::PW'(1) << 29)) >> 30;
        lim = (rnd > p2sc_pkg::PW'(p2sc_pkg::OUT_LIMIT)) ? p2sc_pkg::OUT_LIMIT
                                                          : rnd[p2sc_pkg::POS_W-1:0];
        return neg ? -$signed(lim) : $signed(lim);
    endfunction

    logic                               r_v2;
    logic signed [p2sc_pkg::POS_W-1:0]  r_px;
    logic signed [p2sc_pkg::POS_W-1:0]  r_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p  <= n_p;
            r_q  <= n_q;
            r_px <= round_sat(r_p);
            r_py <= round_sat(r_q);
        end
    end

    assign o_valid = r_v2;
    assign o_pos_x = r_px;
    assign o_pos_y = r_py;

endmodule

`default_nettype wire

[sv/polar_to_scaled_cartesian.sv]
// Polar to scaled Cartesian converter, top level: config registers,
// pipeline enable and output skid. Depends on p2sc_pkg, p2sc_angle,
// p2sc_cordic and p2sc_scale.
//
// Usage:
//   Input stream s_axis carries one scanner point per word: distance and
//   bearing (1/64 degree). Output stream m_axis carries pos_x and pos_y,
//   x_scale*d*sin(theta) and y_scale*d*cos(theta), theta = bearing - 90 deg,
//   rounded to whole units and saturated to +-983025.
//   Throughput: one word per cycle while the receiver does not stall. From
//   input accept to output valid a word passes two angle stages, one stage
//   per CORDIC iteration, two scale/round stages and the output register.
//   The gains x_scale (index 0) and y_scale (index 1) are written through
//   i_cfg_we / i_cfg_index / i_cfg_data while the stream is idle; other
//   indexes are ignored.
//   Reset (i_rst_n low, synchronous) empties the pipeline and loads the
//   gains 6 and 9. When the receiver stalls, one further word is caught in
//   a skid register; after that s_axis_tready drops and the whole pipeline
//   holds until m_axis_tready returns. Nothing is lost or repeated.
`default_nettype none

module polar_to_scaled_cartesian #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_we,
    input  wire  [p2sc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [p2sc_pkg::SCALE_W-1:0]         i_cfg_data,
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [15:0] distance, [30:16] bearing, [31] zero
    input  wire  [p2sc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    // [20:0] pos_x, [41:21] pos_y, [47:42] zero
    output logic [p2sc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    localparam int PAIR_W = 2 * p2sc_pkg::POS_W;

    logic [p2sc_pkg::SCALE_W-1:0] r_x_scale;
    logic [p2sc_pkg::SCALE_W-1:0] r_y_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_scale <= p2sc_pkg::X_SCALE_RST;
            r_y_scale <= p2sc_pkg::Y_SCALE_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == p2sc_pkg::CFG_X_SCALE) begin
                r_x_scale <= i_cfg_data;
            end else if (i_cfg_index == p2sc_pkg::CFG_Y_SCALE) begin
                r_y_scale <= i_cfg_data;
            end
        end
    end

    // the pipeline moves whenever the skid register is free
    logic r_skid_v;
    logic en;
    assign en            = !r_skid_v;
    assign s_axis_tready = en;

    logic           ang_v;
    p2sc_pkg::t_cw  ang_w;
    logic           cor_v;
    p2sc_pkg::t_cw  cor_w;
    logic           sc_v;
    logic signed [p2sc_pkg::POS_W-1:0] sc_px;
    logic signed [p2sc_pkg::POS_W-1:0] sc_py;

    p2sc_angle u_angle (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (s_axis_tvalid),
        .i_distance (s_axis_tdata[p2sc_pkg::DIST_W-1:0]),
        .i_bearing  (s_axis_tdata[p2sc_pkg::DIST_W +: p2sc_pkg::BEAR_W]),
        .o_valid    (ang_v),
        .o_word     (ang_w)
    );

    p2sc_cordic #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (ang_v),
        .i_word  (ang_w),
        .o_valid (cor_v),
        .o_word  (cor_w)
    );

    p2sc_scale u_scale (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (cor_v),
        .i_word    (cor_w),
        .i_x_scale (r_x_scale),
        .i_y_scale (r_y_scale),
        .o_valid   (sc_v),
        .o_pos_x   (sc_px),
        .o_pos_y   (sc_py)
    );

    // output register plus one skid word
    logic              r_out_v;
    logic [PAIR_W-1:0] r_out_d;
    logic [PAIR_W-1:0] r_skid_d;
    logic              push;
    logic              pop;
    logic [PAIR_W-1:0] pair;

    assign push = en && sc_v;
    assign pop  = r_out_v && m_axis_tready;
    assign pair = {sc_py, sc_px};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (pop) begin
                r_skid_v <= 1'b0;
            end
        end else if (push) begin
            if (r_out_v && !pop) begin
                r_skid_v <= 1'b1;
            end else begin
                r_out_v <= 1'b1;
            end
        end else if (pop) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (pop) begin
                r_out_d <= r_skid_d;
            end
        end else if (push) begin
            if (r_out_v && !pop) begin
                r_skid_d <= pair;
            end else begin
                r_out_d <= pair;
            end
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {{(p2sc_pkg::OUT_TDATA_W-PAIR_W){1'b0}}, r_out_d};

endmodule

`default_nettype wire

[sv/p2sc_checker.sv]
// Port-level checks for polar_to_scaled_cartesian, attached by bind.
// Depends on p2sc_pkg for widths and the output limit.
`default_nettype none

module p2sc_checker (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               s_axis_tready,
    input  wire                               m_axis_tvalid,
    input  wire                               m_axis_tready,
    input  wire  [p2sc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    localparam int PX_LO = 0;
    localparam int PY_LO = p2sc_pkg::POS_W;

    logic signed [p2sc_pkg::POS_W-1:0] pos_x;
    logic signed [p2sc_pkg::POS_W-1:0] pos_y;
    logic signed [p2sc_pkg::POS_W-1:0] lim;

    assign pos_x = $signed(m_axis_tdata[PX_LO +: p2sc_pkg::POS_W]);
    assign pos_y = $signed(m_axis_tdata[PY_LO +: p2sc_pkg::POS_W]);
    assign lim   = $signed(p2sc_pkg::OUT_LIMIT);

    // saturation keeps both coordinates inside the stated range
    a_x_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (pos_x <= lim && pos_x >= -lim))
        else $error("pos_x outside saturation range");

    a_y_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (pos_y <= lim && pos_y >= -lim))
        else $error("pos_y outside saturation range");

    // reset empties the output side and frees the input side
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_axis_tvalid && s_axis_tready))
        else $error("output not cleared by reset");

    // a stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled output word changed");

    // the input only backs up while the output is stalled
    a_tready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready) |=> s_axis_tready)
        else $error("input blocked after output drained");

endmodule

bind polar_to_scaled_cartesian p2sc_checker u_p2sc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
